FILE: src/scfle_pkg.sv
// Package: shared constants, command/status types and CRC helper for the line encoder.
`default_nettype none

package scfle_pkg;

    // HDLC flag pattern, sent without stuffing
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    // Reflected CRC-16 polynomial
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    // Number of consecutive ones that forces a stuffed zero
    localparam logic [2:0]  STUFF_RUN = 3'd5;

    // Byte source for the transmit shifter
    localparam logic [1:0] LD_FLAG   = 2'd0;
    localparam logic [1:0] LD_DATA   = 2'd1;
    localparam logic [1:0] LD_CRC_LO = 2'd2;
    localparam logic [1:0] LD_CRC_HI = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;     // latch the incoming payload word
        logic       clear;      // clear CRC, ones run and packer (start of frame)
        logic       load;       // load the transmit shifter
        logic [1:0] load_sel;   // which byte to load
        logic       push;       // push one line symbol into the packer
        logic       sym;        // symbol value
        logic       bit_end;    // last symbol of a line bit: shift, update run
        logic       stuffable;  // bit counts toward the ones run
        logic       flush;      // release the held line byte as final of the run
        logic       frame_end;  // mark the released byte as end of frame
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cur_bit;     // line bit now at the head of the shifter
        logic will_stuff;  // this bit completes a run of ones
        logic push_ok;     // a symbol push will not lose a line byte
        logic pack_empty;  // packer sits on a byte boundary
        logic pend_valid;  // a completed line byte is held back
        logic out_free;    // output register can take a word this cycle
    } dp_stat_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc8_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/scfle_dp.sv
// Datapath: CRC, transmit shifter, ones run, symbol packer, hold stage and output register.
`default_nettype none

module scfle_dp
    import scfle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    output logic            dst_valid,
    input  wire logic       dst_stall,
    output logic [7:0]      line_byte,
    output logic            last_of_run,
    output logic            frame_end
);

    logic [7:0]  data_reg,   data_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [2:0]  run_reg,    run_next;
    logic [7:0]  tx_reg,     tx_next;
    logic [7:0]  pack_reg,   pack_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [7:0]  pend_reg,   pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic        out_last_reg,   out_last_next;
    logic        out_end_reg,    out_end_next;

    logic [7:0]  pack_new;
    logic        byte_done;
    logic        out_free;

    assign pack_new  = {cmd.sym, pack_reg[7:1]};
    assign byte_done = cmd.push && (cnt_reg == 3'd7);
    assign out_free  = !out_valid_reg || !dst_stall;

    // Report status to the controller
    always_comb
    begin
        stat.cur_bit    = tx_reg[7];
        stat.will_stuff = tx_reg[7] && (run_reg == (STUFF_RUN - 3'd1));
        stat.push_ok    = !((cnt_reg == 3'd7) && pend_valid_reg && !out_free);
        stat.pack_empty = (cnt_reg == 3'd0);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    // Frame state, shifter and packer
    always_comb
    begin
        data_next   = data_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        run_next    = run_reg;
        tx_next     = tx_reg;
        pack_next   = pack_reg;
        cnt_next    = cnt_reg;

        if (cmd.accept)
            data_next = data_byte;

        if (cmd.clear)
        begin
            crc_next  = '0;
            run_next  = '0;
            pack_next = '0;
            cnt_next  = '0;
        end

        // Load the next byte to send; payload and CRC bytes feed the CRC
        if (cmd.load)
        begin
            case (cmd.load_sel)
                LD_FLAG:
                begin
                    tx_next = FLAG_BYTE;
                end
                LD_DATA:
                begin
                    tx_next  = data_reg;
                    crc_next = crc8_update(crc_reg, data_reg);
                end
                LD_CRC_LO:
                begin
                    tx_next     = crc_reg[7:0];
                    crc_hi_next = crc_reg[15:8];
                    crc_next    = crc8_update(crc_reg, crc_reg[7:0]);
                end
                LD_CRC_HI:
                begin
                    tx_next  = crc_hi_reg;
                    crc_next = crc8_update(crc_reg, crc_hi_reg);
                end
                default:
                begin
                    tx_next = FLAG_BYTE;
                end
            endcase
        end

        // Advance the shifter and the ones run at the end of a line bit
        if (cmd.bit_end)
        begin
            tx_next = {tx_reg[6:0], 1'b0};
            if (cmd.stuffable)
            begin
                if (!tx_reg[7])
                    run_next = '0;
                else if (run_reg == (STUFF_RUN - 3'd1))
                    run_next = '0;
                else
                    run_next = run_reg + 3'd1;
            end
        end

        // Pack symbols LSB first
        if (cmd.push)
        begin
            pack_next = pack_new;
            cnt_next  = cnt_reg + 3'd1;
        end
    end

    // Hold stage and output register
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;

        if (out_valid_reg && !dst_stall)
            out_valid_next = 1'b0;

        // A newer byte proves the held one is not the last of the run
        if (byte_done)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_reg;
                out_last_next  = 1'b0;
                out_end_next   = 1'b0;
            end
            pend_next       = pack_new;
            pend_valid_next = 1'b1;
        end

        // Release the held byte as the last of the run
        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_reg;
            out_last_next   = 1'b1;
            out_end_next    = cmd.frame_end;
            pend_valid_next = 1'b0;
        end
    end

    // Control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            run_reg        <= '0;
            pack_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            crc_reg        <= crc_next;
            run_reg        <= run_next;
            pack_reg       <= pack_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        crc_hi_reg   <= crc_hi_next;
        tx_reg       <= tx_next;
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign dst_valid   = out_valid_reg;
    assign line_byte   = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign frame_end   = out_end_reg;

`ifndef SYNTHESIS
    // A completed byte never overwrites a held byte that cannot move on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_done && pend_valid_reg) |-> out_free)
        else $error("line byte overrun in hold stage");

    // A flush always has a held byte and room at the output
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (pend_valid_reg && out_free))
        else $error("flush without held byte or output room");

    // A flush shows up as a final word of the run
    a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("flush did not present final word");

    // The ones run never reaches the stuffing length
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg < STUFF_RUN)
        else $error("ones run out of range");
`endif

endmodule

`default_nettype wire

FILE: src/scfle_ctrl.sv
// Controller: sequences flags, payload, CRC bytes, stuffing, padding and the final flush.
`default_nettype none

module scfle_ctrl
    import scfle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire logic     first_of_frame,
    input  wire logic     last_of_frame,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_BIT   = 3'd2;
    localparam logic [2:0] ST_STUFF = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    localparam logic [2:0] PH_FLAG1  = 3'd0;
    localparam logic [2:0] PH_DATA   = 3'd1;
    localparam logic [2:0] PH_CRC_LO = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_FLAG2  = 3'd4;

    logic [2:0] state_reg,   state_next;
    logic [2:0] phase_reg,   phase_next;
    logic       last_reg,    last_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [1:0] sym_idx_reg, sym_idx_next;

    logic       data_phase;
    logic [1:0] bit_sym_last;
    logic       bit_step;

    assign src_stall = (state_reg != ST_IDLE);

    // Sequence one line symbol per cycle while the datapath reports push_ok
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        last_next    = last_reg;
        bit_cnt_next = bit_cnt_reg;
        sym_idx_next = sym_idx_reg;
        cmd          = '0;
        bit_step     = 1'b0;

        data_phase   = phase_reg inside {PH_DATA, PH_CRC_LO, PH_CRC_HI};
        // a one is sent as 001, a zero as 01
        bit_sym_last = stat.cur_bit ? 2'd2 : 2'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.clear  = first_of_frame;
                    last_next  = last_of_frame;
                    phase_next = first_of_frame ? PH_FLAG1 : PH_DATA;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                case (phase_reg)
                    PH_DATA:   cmd.load_sel = LD_DATA;
                    PH_CRC_LO: cmd.load_sel = LD_CRC_LO;
                    PH_CRC_HI: cmd.load_sel = LD_CRC_HI;
                    default:   cmd.load_sel = LD_FLAG;
                endcase
                bit_cnt_next = '0;
                sym_idx_next = '0;
                state_next   = ST_BIT;
            end
            ST_BIT:
            begin
                if (stat.push_ok)
                begin
                    cmd.push = 1'b1;
                    cmd.sym  = (sym_idx_reg == bit_sym_last);
                    if (sym_idx_reg == bit_sym_last)
                    begin
                        cmd.bit_end   = 1'b1;
                        cmd.stuffable = data_phase;
                        sym_idx_next  = '0;
                        if (data_phase && stat.will_stuff)
                            state_next = ST_STUFF;
                        else
                            bit_step = 1'b1;
                    end
                    else
                    begin
                        sym_idx_next = sym_idx_reg + 2'd1;
                    end
                end
            end
            ST_STUFF:
            begin
                // stuffed zero: symbols 01
                if (stat.push_ok)
                begin
                    cmd.push = 1'b1;
                    cmd.sym  = (sym_idx_reg == 2'd1);
                    if (sym_idx_reg == 2'd1)
                    begin
                        sym_idx_next = '0;
                        bit_step     = 1'b1;
                    end
                    else
                    begin
                        sym_idx_next = sym_idx_reg + 2'd1;
                    end
                end
            end
            ST_PAD:
            begin
                if (stat.pack_empty)
                begin
                    state_next = ST_FLUSH;
                end
                else if (stat.push_ok)
                begin
                    cmd.push = 1'b1;
                    cmd.sym  = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush     = 1'b1;
                    cmd.frame_end = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next bit, or to the next byte of the frame
        if (bit_step)
        begin
            if (bit_cnt_reg != 3'd7)
            begin
                bit_cnt_next = bit_cnt_reg + 3'd1;
                state_next   = ST_BIT;
            end
            else
            begin
                case (phase_reg)
                    PH_FLAG1:
                    begin
                        phase_next = PH_DATA;
                        state_next = ST_LOAD;
                    end
                    PH_DATA:
                    begin
                        if (last_reg)
                        begin
                            phase_next = PH_CRC_LO;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    PH_CRC_LO:
                    begin
                        phase_next = PH_CRC_HI;
                        state_next = ST_LOAD;
                    end
                    PH_CRC_HI:
                    begin
                        phase_next = PH_FLAG2;
                        state_next = ST_LOAD;
                    end
                    PH_FLAG2:
                    begin
                        state_next = ST_PAD;
                    end
                    default:
                    begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FLAG1;
            last_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            sym_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            last_reg    <= last_next;
            bit_cnt_reg <= bit_cnt_next;
            sym_idx_reg <= sym_idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/stuffed_crc_frame_line_encoder_core.sv
// Top level: bit-stuffing CRC-16 frame line encoder, controller plus datapath.
//
// Usage: payload words (data_byte with first_of_frame / last_of_frame marks) enter on the
// src channel (src_valid / src_stall); line bytes leave on the dst channel (dst_valid /
// dst_stall) with last_of_run on the final line byte caused by a payload word and
// frame_end on the padded closing byte of a frame.
// One payload word is worked at a time; src_stall is high from acceptance until its last
// line byte has moved into the output register.
// The controller emits one line symbol per cycle while push_ok allows it: 2 symbols per zero
// bit, 3 per one bit, 2 more per stuffed zero, plus one load step per byte sent.
// A plain payload word passes through accept, load, 16..28 symbols and flush; a first mark
// adds a flag (a load and 22 symbols); a last mark adds two CRC bytes, a closing flag, a
// pad check and up to 7 padding symbols.
// The latest completed line byte is held back one stage until it is known whether it is
// the last of its run; the final flush waits for the output register to be free, so a
// word stalled at the output holds off acceptance of the next payload word.
// When dst_stall is high, symbol generation pauses when a new line byte completes with
// both the hold stage and the output register full, and the flush waits as above.
// Reset (rst_n, asynchronous) clears the CRC, ones run, packer and all valid flags.
`default_nettype none

module stuffed_crc_frame_line_encoder_core
    import scfle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    output logic            src_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_of_frame,
    input  wire logic       last_of_frame,
    output logic            dst_valid,
    input  wire logic       dst_stall,
    output logic [7:0]      line_byte,
    output logic            last_of_run,
    output logic            frame_end
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    scfle_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .cmd            (cmd),
        .stat           (stat)
    );

    // CRC, stuffing, symbol packing and output
    scfle_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .line_byte   (line_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the stuffed CRC-16 frame line encoder: directed table, then random frames.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIR_ROWS    = 16;
    localparam int          RAND_WORDS  = 334;
    localparam int          CALM_TAIL   = 40;
    localparam int          MAX_LINES   = 20;
    localparam int          PRESS_AFTER = 30;
    localparam int          PRESS_HOLD  = 400;
    localparam logic [15:0] KERMIT_POLY = 16'h8408;
    localparam logic [7:0]  HDLC_FLAG   = 8'h7E;
    localparam logic [2:0]  ONES_LIMIT  = 3'd5;

    typedef enum logic [1:0] {ROW_MODEL, ROW_TYPED, ROW_ALIGN_END} row_kind_t;

    // One directed word; typed rows carry up to four line bytes, earliest in the top byte
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        row_kind_t   kind;
        logic [2:0]  typed_n;
        logic [31:0] typed_lines;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] crc;
        logic [2:0]  ones_seen;
        logic [7:0]  pack_reg;
        logic [2:0]  pack_fill;
    } framer_state_t;

    typedef struct packed {
        logic [7:0] bits;
        logic       run_end;
        logic       frame_done;
    } line_word_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       dst_valid;
    logic       dst_stall;
    logic [7:0] line_byte;
    logic       last_of_run;
    logic       frame_end;

    framer_state_t tx_model;
    line_word_t    tx_out [MAX_LINES];
    int            tx_lines;
    int            tx_pad;
    line_word_t    line_expect_q [$];
    stim_row_t     dir_tab [DIR_ROWS];
    int            words_taken = 0;
    int            line_mismatches = 0;
    logic          tail_calm = 1'b0;

    stuffed_crc_frame_line_encoder_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .data_byte      (data_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .dst_valid      (dst_valid),
        .dst_stall      (dst_stall),
        .line_byte      (line_byte),
        .last_of_run    (last_of_run),
        .frame_end      (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift one line symbol into the packer, LSB first; emit on the eighth
    function automatic void frame_pack_symbol(input logic sym);
        tx_model.pack_reg = {sym, tx_model.pack_reg[7:1]};
        if (tx_model.pack_fill == 3'd7 && tx_lines < MAX_LINES)
        begin
            tx_out[tx_lines] = {tx_model.pack_reg, 1'b0, 1'b0};
            tx_lines++;
        end
        tx_model.pack_fill = tx_model.pack_fill + 3'd1;
    endfunction

    // Zero becomes 01, one becomes 001, earliest symbol first
    function automatic void frame_bit_symbols(input logic one);
        frame_pack_symbol(1'b0);
        if (one)
            frame_pack_symbol(1'b0);
        frame_pack_symbol(1'b1);
    endfunction

    // Flag goes out as is: no stuffing, ones run untouched
    function automatic void frame_send_flag();
        for (int k = 7; k >= 0; k--)
            frame_bit_symbols(HDLC_FLAG[k]);
    endfunction

    // Fold a byte into the reflected CRC, then send it MSB first with zero stuffing
    function automatic void frame_send_octet(input logic [7:0] d);
        logic [15:0] c;
        c = tx_model.crc ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ KERMIT_POLY) : (c >> 1);
        tx_model.crc = c;
        for (int k = 7; k >= 0; k--)
        begin
            if (d[k])
                tx_model.ones_seen = tx_model.ones_seen + 3'd1;
            else
                tx_model.ones_seen = 3'd0;
            frame_bit_symbols(d[k]);
            if (tx_model.ones_seen >= ONES_LIMIT)
            begin
                tx_model.ones_seen = 3'd0;
                frame_bit_symbols(1'b0);
            end
        end
    endfunction

    // Work out the line bytes that one payload word releases
    function automatic void frame_encode_word(input logic [7:0] d, input logic f, input logic l);
        logic [15:0] crc_snap;
        tx_lines = 0;
        tx_pad   = 0;
        if (f)
        begin
            tx_model = '0;
            frame_send_flag();
        end
        frame_send_octet(d);
        if (l)
        begin
            crc_snap = tx_model.crc;
            frame_send_octet(crc_snap[7:0]);
            frame_send_octet(crc_snap[15:8]);
            frame_send_flag();
            while (tx_model.pack_fill != 3'd0)
            begin
                frame_pack_symbol(1'b1);
                tx_pad++;
            end
            if (tx_lines > 0)
                tx_out[tx_lines - 1].frame_done = 1'b1;
        end
        if (tx_lines > 0)
            tx_out[tx_lines - 1].run_end = 1'b1;
    endfunction

    // Offer one word, hold it until taken, then book its line bytes if book is set
    task automatic offer_word(input logic [7:0] d, input logic f, input logic l, input logic book);
        if (!tail_calm && (words_taken % 48) < 32 && $urandom_range(0, 2) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        src_valid      <= 1'b1;
        data_byte      <= d;
        first_of_frame <= f;
        last_of_frame  <= l;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        words_taken++;
        tail_calm = (words_taken >= DIR_ROWS + RAND_WORDS - CALM_TAIL);
        frame_encode_word(d, f, l);
        if (book)
            for (int k = 0; k < tx_lines; k++)
                line_expect_q.push_back(tx_out[k]);
    endtask

    // Sender: reset, directed table, random frames, drain
    initial
    begin : src_side
        stim_row_t     row;
        framer_state_t saved;
        line_word_t    lw;
        logic [7:0]    wd;
        int            rand_sent;
        int            frame_len;

        src_valid      <= 1'b0;
        data_byte      <= 8'h00;
        first_of_frame <= 1'b0;
        last_of_frame  <= 1'b0;
        rst_n          <= 1'b0;
        tx_model = '0;

        // Every word yields at least sixteen symbols, so no word ends without a line byte
        dir_tab[0]  = {8'h00, 1'b1, 1'b0, ROW_TYPED,     3'd4, 32'h9224_A9AA};
        dir_tab[1]  = {8'hFF, 1'b0, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[2]  = {8'h55, 1'b0, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[3]  = {8'hAA, 1'b0, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[4]  = {8'h80, 1'b0, 1'b1, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[5]  = {8'h01, 1'b0, 1'b1, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[6]  = {8'hFF, 1'b1, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[7]  = {8'h7E, 1'b1, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[8]  = {8'h3C, 1'b0, 1'b1, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[9]  = {8'hFF, 1'b1, 1'b1, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[10] = {8'h00, 1'b1, 1'b1, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[11] = {8'h00, 1'b1, 1'b1, ROW_ALIGN_END, 3'd0, 32'h0};
        dir_tab[12] = {8'hF8, 1'b1, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[13] = {8'h1F, 1'b0, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[14] = {8'hFF, 1'b0, 1'b0, ROW_MODEL,     3'd0, 32'h0};
        dir_tab[15] = {8'hFF, 1'b0, 1'b1, ROW_MODEL,     3'd0, 32'h0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_tab[r];
            wd  = row.data;
            // Pick a one-word frame whose closing flag lands on a byte boundary
            if (row.kind == ROW_ALIGN_END)
            begin
                saved = tx_model;
                for (int v = 0; v < 256; v++)
                begin
                    frame_encode_word(8'(v), 1'b1, 1'b1);
                    tx_model = saved;
                    if (tx_pad == 0)
                    begin
                        wd = 8'(v);
                        break;
                    end
                end
            end
            offer_word(wd, row.first, row.last, row.kind != ROW_TYPED);
            if (row.kind == ROW_TYPED)
                for (int k = 0; k < row.typed_n; k++)
                begin
                    lw.bits       = row.typed_lines[31 - 8 * k -: 8];
                    lw.run_end    = (k == row.typed_n - 1);
                    lw.frame_done = row.last && (k == row.typed_n - 1);
                    line_expect_q.push_back(lw);
                end
        end

        // Mostly whole frames with random content, some loose words with random marks
        rand_sent = 0;
        while (rand_sent < RAND_WORDS)
        begin
            frame_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : 1;
            for (int k = 0; k < frame_len && rand_sent < RAND_WORDS; k++)
            begin
                wd = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0)
                    wd |= 8'($urandom);
                if (frame_len == 1 && $urandom_range(0, 4) == 0)
                    offer_word(wd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
                else
                    offer_word(wd, k == 0, k == frame_len - 1, 1'b1);
                rand_sent++;
            end
        end
        src_valid <= 1'b0;

        while (line_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (line_mismatches == 0)
            $display("** stuffed_crc_frame_line_encoder_core: PASSED **");
        else
            $display("** stuffed_crc_frame_line_encoder_core: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts, quiet stretches, one long hold-off
    initial
    begin : dst_side
        int  hold;
        int  quiet_left;
        int  pick;
        logic pressed;

        quiet_left = 0;
        pressed    = 1'b0;
        dst_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!pressed && words_taken >= PRESS_AFTER)
            begin
                pressed = 1'b1;
                dst_stall <= 1'b1;
                hold = 0;
                while (hold < PRESS_HOLD)
                begin
                    @(posedge clk);
                    hold++;
                end
                dst_stall <= 1'b0;
            end
            else if (quiet_left > 0)
                quiet_left--;
            else if (!tail_calm)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    dst_stall <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                    dst_stall <= 1'b0;
                end
                else if (pick == 3)
                    quiet_left = $urandom_range(20, 80);
            end
        end
    end

    // Compare each accepted line word against the oldest expectation
    always @(posedge clk)
    begin : line_check
        line_word_t want;
        if (rst_n === 1'b1 && dst_valid === 1'b1 && dst_stall === 1'b0)
        begin
            if (line_expect_q.size() == 0)
            begin
                line_mismatches++;
                $display("%0t: unexpected line word: expected none, got %02h run_end %b frame_end %b",
                         $time, line_byte, last_of_run, frame_end);
            end
            else
            begin
                want = line_expect_q.pop_front();
                if (line_byte !== want.bits)
                begin
                    line_mismatches++;
                    $display("%0t: line_byte expected %02h got %02h", $time, want.bits, line_byte);
                end
                if (last_of_run !== want.run_end)
                begin
                    line_mismatches++;
                    $display("%0t: last_of_run expected %b got %b", $time, want.run_end,
                             last_of_run);
                end
                if (frame_end !== want.frame_done)
                begin
                    line_mismatches++;
                    $display("%0t: frame_end expected %b got %b", $time, want.frame_done,
                             frame_end);
                end
            end
        end
    end

    // Bail out if the run hangs
    initial
    begin
        #5_000_000;
        $display("** stuffed_crc_frame_line_encoder_core: FAILED **");
        $finish;
    end

endmodule
